// File: rtl/core/tgf_pkg.sv
package tgf_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int FRAC_BITS_DEFAULT   = 16;

   // fixed widths of the result fields
   localparam int JAC_W     = 50;
   localparam int FACTOR_W  = 32;
   // quotient bits developed per division: factor width, one overflow bit, one rounding bit
   localparam int QUOT_W    = FACTOR_W + 2;
   localparam int NUM_LANES = 7;

   // division lanes
   localparam int LANE_RX = 0;
   localparam int LANE_RY = 1;
   localparam int LANE_SX = 2;
   localparam int LANE_SY = 3;
   localparam int LANE_RR = 4;
   localparam int LANE_RS = 5;
   localparam int LANE_SS = 6;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NEG  = 2'd1,
      STATUS_ZERO = 2'd2
   } status_type;

   // per-request information that rides alongside the dividers
   typedef struct packed {
      logic [JAC_W-1:0] jacobian;
      status_type       status;
      logic             final_flag;
   } side_type;

   typedef struct packed {
      logic [JAC_W-1:0]                         jacobian;
      logic [NUM_LANES-1:0][FACTOR_W-1:0]       factor;
      status_type                               status;
      logic                                     final_flag;
   } rsp_type;

endpackage

// File: rtl/core/tgf_req_if.sv
interface tgf_req_if #(
   parameter int COORD_W = 24
) ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] x_vertex_one;
   logic [COORD_W-1:0] x_vertex_two;
   logic [COORD_W-1:0] x_vertex_three;
   logic [COORD_W-1:0] y_vertex_one;
   logic [COORD_W-1:0] y_vertex_two;
   logic [COORD_W-1:0] y_vertex_three;
   logic               final_element;

   modport source (
      output valid, x_vertex_one, x_vertex_two, x_vertex_three,
             y_vertex_one, y_vertex_two, y_vertex_three, final_element,
      input  ready
   );

   modport sink (
      input  valid, x_vertex_one, x_vertex_two, x_vertex_three,
             y_vertex_one, y_vertex_two, y_vertex_three, final_element,
      output ready
   );
endinterface

// File: rtl/core/tgf_rsp_if.sv
interface tgf_rsp_if import tgf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [JAC_W-1:0]    jacobian;
   logic [FACTOR_W-1:0] r_dx;
   logic [FACTOR_W-1:0] r_dy;
   logic [FACTOR_W-1:0] s_dx;
   logic [FACTOR_W-1:0] s_dy;
   logic [FACTOR_W-1:0] metric_rr;
   logic [FACTOR_W-1:0] metric_rs;
   logic [FACTOR_W-1:0] metric_ss;
   logic [1:0]          status;
   logic                final_result;

   modport source (
      output valid, jacobian, r_dx, r_dy, s_dx, s_dy, metric_rr, metric_rs, metric_ss,
             status, final_result,
      input  ready
   );

   modport sink (
      input  valid, jacobian, r_dx, r_dy, s_dx, s_dy, metric_rr, metric_rs, metric_ss,
             status, final_result,
      output ready
   );
endinterface

// File: rtl/core/triangle_geometric_factors_unit.sv
// affine geometric factors of one 2d triangle per request. takes the three vertex
// coordinates (signed, COORD_WIDTH bits, half of them fraction) and returns the
// jacobian j = c/4 of the edge cross product c (twice the coordinate fraction bits,
// saturated to 50 bits), the four inverse-map factors rx, ry, sx, sy and the three
// metric terms g00, g01, g11, each in signed 32-bit fixed point with
// FACTOR_FRAC_BITS fraction bits, rounded to nearest (ties away from zero) and
// saturated. a negative c gives status 1 and a zero c status 2; in both the seven
// factors are zero and jacobian still carries j. throughput is one request per
// clock while no stall holds the pipeline. a request passes the front-end stages
// for differences, products, sums, magnitudes and overflow test, then the
// restoring division stages (one quotient bit per stage, seven lanes sharing the divisor
// c), then the rounding and output register. a stall on the response side freezes
// the whole pipeline after one extra response has been parked in a skid register,
// so req_bus.ready is a register and does not follow rsp_bus.ready combinationally.
module triangle_geometric_factors_unit
   import tgf_pkg::*;
#(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEFAULT,
   parameter int FACTOR_FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tgf_req_if.sink     req_bus,
   tgf_rsp_if.source   rsp_bus
);

   // divisor and partial remainder width, matches the signed cross product
   localparam int REM_W = 2 * (COORD_WIDTH + 1) + 1;

   logic                                        advance;

   // divider chain, index 0 is the front end output
   logic [QUOT_W:0]                             div_vld;
   logic [QUOT_W:0][REM_W-1:0]                  div_dvs;
   logic [QUOT_W:0][NUM_LANES-1:0][REM_W-1:0]   div_rem;
   logic [QUOT_W:0][NUM_LANES-1:0][QUOT_W-1:0]  div_quot;
   logic [QUOT_W:0][NUM_LANES-1:0]              div_neg;
   logic [QUOT_W:0][NUM_LANES-1:0]              div_ovf;
   side_type [QUOT_W:0]                         div_side;

   rsp_type                                     rsp_data;

   assign req_bus.ready = advance;

   // differences, products, sums and overflow test
   tgf_front #(
      .COORD_W (COORD_WIDTH),
      .FRAC_W  (FACTOR_FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_bus.valid),
      .x1          (req_bus.x_vertex_one),
      .x2          (req_bus.x_vertex_two),
      .x3          (req_bus.x_vertex_three),
      .y1          (req_bus.y_vertex_one),
      .y2          (req_bus.y_vertex_two),
      .y3          (req_bus.y_vertex_three),
      .in_final    (req_bus.final_element),
      .out_valid   (div_vld[0]),
      .out_divisor (div_dvs[0]),
      .out_rem     (div_rem[0]),
      .out_quot    (div_quot[0]),
      .out_neg     (div_neg[0]),
      .out_ovf     (div_ovf[0]),
      .out_side    (div_side[0])
   );

   // one quotient bit per stage
   for (genvar g = 0; g < QUOT_W; g++) begin : g_div
      tgf_div_stage #(
         .REM_W (REM_W)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (div_vld[g]),
         .in_divisor  (div_dvs[g]),
         .in_rem      (div_rem[g]),
         .in_quot     (div_quot[g]),
         .in_neg      (div_neg[g]),
         .in_ovf      (div_ovf[g]),
         .in_side     (div_side[g]),
         .out_valid   (div_vld[g+1]),
         .out_divisor (div_dvs[g+1]),
         .out_rem     (div_rem[g+1]),
         .out_quot    (div_quot[g+1]),
         .out_neg     (div_neg[g+1]),
         .out_ovf     (div_ovf[g+1]),
         .out_side    (div_side[g+1])
      );
   end

   // rounding, saturation and output register with skid
   tgf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_vld[QUOT_W]),
      .in_quot   (div_quot[QUOT_W]),
      .in_neg    (div_neg[QUOT_W]),
      .in_ovf    (div_ovf[QUOT_W]),
      .in_side   (div_side[QUOT_W]),
      .advance   (advance),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.jacobian     = rsp_data.jacobian;
   assign rsp_bus.r_dx         = rsp_data.factor[LANE_RX];
   assign rsp_bus.r_dy         = rsp_data.factor[LANE_RY];
   assign rsp_bus.s_dx         = rsp_data.factor[LANE_SX];
   assign rsp_bus.s_dy         = rsp_data.factor[LANE_SY];
   assign rsp_bus.metric_rr    = rsp_data.factor[LANE_RR];
   assign rsp_bus.metric_rs    = rsp_data.factor[LANE_RS];
   assign rsp_bus.metric_ss    = rsp_data.factor[LANE_SS];
   assign rsp_bus.status       = rsp_data.status;
   assign rsp_bus.final_result = rsp_data.final_flag;

`ifndef SYNTH
   // a parked response means the output register is occupied
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("skid full while output register empty");

   // a stall must freeze the divider chain
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |=> $stable(div_vld))
      else $error("divider chain moved during stall");

   // error responses carry no factors
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != STATUS_OK) |->
         (rsp_bus.r_dx == '0 && rsp_bus.s_dy == '0 && rsp_bus.metric_rs == '0))
      else $error("factors not cleared on error status");

   // degenerate triangle has zero jacobian
   a_zero_jac: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == STATUS_ZERO) |-> rsp_bus.jacobian == '0)
      else $error("nonzero jacobian with zero status");
`endif

endmodule

// File: rtl/core/tgf_front.sv
module tgf_front
   import tgf_pkg::*;
#(
   parameter int COORD_W = COORD_WIDTH_DEFAULT,
   parameter int FRAC_W  = FRAC_BITS_DEFAULT,
   localparam int REM_W  = 2 * (COORD_W + 1) + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [COORD_W-1:0]                   x1,
   input  logic [COORD_W-1:0]                   x2,
   input  logic [COORD_W-1:0]                   x3,
   input  logic [COORD_W-1:0]                   y1,
   input  logic [COORD_W-1:0]                   y2,
   input  logic [COORD_W-1:0]                   y3,
   input  logic                                 in_final,
   output logic                                 out_valid,
   output logic [REM_W-1:0]                     out_divisor,
   output logic [NUM_LANES-1:0][REM_W-1:0]      out_rem,
   output logic [NUM_LANES-1:0][QUOT_W-1:0]     out_quot,
   output logic [NUM_LANES-1:0]                 out_neg,
   output logic [NUM_LANES-1:0]                 out_ovf,
   output side_type                             out_side
);

   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int JQ_W    = CROSS_W - 2;
   localparam int SHIFT_R = COORD_W / 2 + 1 + FRAC_W;
   localparam int NUM_W   = 2 * COORD_W + FRAC_W + COORD_W / 2 + 3;
   localparam int TOP_W   = NUM_W + 1 - QUOT_W;
   localparam int CMP_W   = (TOP_W > REM_W) ? TOP_W : REM_W;
   localparam int EXT_W   = ((JQ_W > JAC_W) ? JQ_W : JAC_W) + 1;
   localparam logic [EXT_W-1:0] J_HALF = EXT_W'(1) << (JAC_W - 1);
   localparam logic [EXT_W-1:0] J_MAX  = J_HALF - EXT_W'(1);

   function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? -v : v;
   endfunction

   // stage 1: edge differences
   logic                     s1_valid_ff, s1_final_ff;
   logic signed [DIFF_W-1:0] s1_dx12_ff, s1_dy12_ff, s1_dx13_ff, s1_dy13_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx12_ff  <= {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
         s1_dy12_ff  <= {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
         s1_dx13_ff  <= {x3[COORD_W-1], x3} - {x1[COORD_W-1], x1};
         s1_dy13_ff  <= {y3[COORD_W-1], y3} - {y1[COORD_W-1], y1};
         s1_final_ff <= in_final;
      end
   end

   // stage 2: products
   logic                     s2_valid_ff, s2_final_ff;
   logic signed [DIFF_W-1:0] s2_dx12_ff, s2_dy12_ff, s2_dx13_ff, s2_dy13_ff;
   logic signed [PROD_W-1:0] s2_c1_ff, s2_c2_ff, s2_xx13_ff, s2_yy13_ff;
   logic signed [PROD_W-1:0] s2_xx12_ff, s2_yy12_ff, s2_xm_ff, s2_ym_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_c1_ff    <= s1_dx12_ff * s1_dy13_ff;
         s2_c2_ff    <= s1_dx13_ff * s1_dy12_ff;
         s2_xx13_ff  <= s1_dx13_ff * s1_dx13_ff;
         s2_yy13_ff  <= s1_dy13_ff * s1_dy13_ff;
         s2_xx12_ff  <= s1_dx12_ff * s1_dx12_ff;
         s2_yy12_ff  <= s1_dy12_ff * s1_dy12_ff;
         s2_xm_ff    <= s1_dx13_ff * s1_dx12_ff;
         s2_ym_ff    <= s1_dy13_ff * s1_dy12_ff;
         s2_dx12_ff  <= s1_dx12_ff;
         s2_dy12_ff  <= s1_dy12_ff;
         s2_dx13_ff  <= s1_dx13_ff;
         s2_dy13_ff  <= s1_dy13_ff;
         s2_final_ff <= s1_final_ff;
      end
   end

   // stage 3: cross product and metric sums
   logic                      s3_valid_ff, s3_final_ff;
   logic signed [DIFF_W-1:0]  s3_dx12_ff, s3_dy12_ff, s3_dx13_ff, s3_dy13_ff;
   logic signed [CROSS_W-1:0] s3_cross_ff, s3_m00_ff, s3_dot_ff, s3_m11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_cross_ff <= CROSS_W'(s2_c1_ff) - CROSS_W'(s2_c2_ff);
         s3_m00_ff   <= CROSS_W'(s2_xx13_ff) + CROSS_W'(s2_yy13_ff);
         s3_dot_ff   <= CROSS_W'(s2_xm_ff) + CROSS_W'(s2_ym_ff);
         s3_m11_ff   <= CROSS_W'(s2_xx12_ff) + CROSS_W'(s2_yy12_ff);
         s3_dx12_ff  <= s2_dx12_ff;
         s3_dy12_ff  <= s2_dy12_ff;
         s3_dx13_ff  <= s2_dx13_ff;
         s3_dy13_ff  <= s2_dy13_ff;
         s3_final_ff <= s2_final_ff;
      end
   end

   // stage 4: magnitudes, rounded quarter of |c|, status
   logic                                s4_valid_ff, s4_final_ff;
   logic [CROSS_W-1:0]                  s4_abs_in;
   logic [JQ_W-1:0]                     s4_jq_ff;
   logic                                s4_cneg_ff;
   status_type                          s4_status_in, s4_status_ff;
   logic [REM_W-1:0]                    s4_div_ff;
   logic [NUM_LANES-1:0][NUM_W-1:0]     s4_num_in, s4_num_ff;
   logic [NUM_LANES-1:0]                s4_neg_in, s4_neg_ff;
   logic [CROSS_W-1:0]                  s4_dot_abs;

   always_comb begin
      s4_abs_in  = s3_cross_ff[CROSS_W-1] ? -s3_cross_ff : s3_cross_ff;
      s4_dot_abs = s3_dot_ff[CROSS_W-1] ? -s3_dot_ff : s3_dot_ff;

      if (s3_cross_ff == '0) begin
         s4_status_in = STATUS_ZERO;
      end else if (s3_cross_ff[CROSS_W-1]) begin
         s4_status_in = STATUS_NEG;
      end else begin
         s4_status_in = STATUS_OK;
      end

      s4_num_in[LANE_RX] = NUM_W'(mag_diff(s3_dy13_ff)) << SHIFT_R;
      s4_neg_in[LANE_RX] = s3_dy13_ff[DIFF_W-1];
      s4_num_in[LANE_RY] = NUM_W'(mag_diff(s3_dx13_ff)) << SHIFT_R;
      s4_neg_in[LANE_RY] = ~s3_dx13_ff[DIFF_W-1];
      s4_num_in[LANE_SX] = NUM_W'(mag_diff(s3_dy12_ff)) << SHIFT_R;
      s4_neg_in[LANE_SX] = ~s3_dy12_ff[DIFF_W-1];
      s4_num_in[LANE_SY] = NUM_W'(mag_diff(s3_dx12_ff)) << SHIFT_R;
      s4_neg_in[LANE_SY] = s3_dx12_ff[DIFF_W-1];
      s4_num_in[LANE_RR] = NUM_W'(unsigned'(s3_m00_ff)) << FRAC_W;
      s4_neg_in[LANE_RR] = 1'b0;
      // the off-diagonal term carries a minus sign
      s4_num_in[LANE_RS] = NUM_W'(s4_dot_abs) << FRAC_W;
      s4_neg_in[LANE_RS] = ~s3_dot_ff[CROSS_W-1];
      s4_num_in[LANE_SS] = NUM_W'(unsigned'(s3_m11_ff)) << FRAC_W;
      s4_neg_in[LANE_SS] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_jq_ff     <= JQ_W'(s4_abs_in[CROSS_W-1:2]) + JQ_W'(s4_abs_in[1]);
         s4_cneg_ff   <= s3_cross_ff[CROSS_W-1];
         s4_status_ff <= s4_status_in;
         s4_div_ff    <= s3_cross_ff;
         s4_num_ff    <= s4_num_in;
         s4_neg_ff    <= s4_neg_in;
         s4_final_ff  <= s3_final_ff;
      end
   end

   // stage 5: saturate j, overflow test and first partial remainder
   logic [EXT_W-1:0]                    s5_jq_ext;
   logic [JAC_W-1:0]                    s5_jac_in;
   logic [NUM_LANES-1:0][NUM_W:0]       s5_twice;
   logic [NUM_LANES-1:0][TOP_W-1:0]     s5_top;
   logic [NUM_LANES-1:0][REM_W-1:0]     s5_rem_in;
   logic [NUM_LANES-1:0][QUOT_W-1:0]    s5_quot_in;
   logic [NUM_LANES-1:0]                s5_ovf_in;
   logic                                s5_valid_ff;
   logic [REM_W-1:0]                    s5_div_ff;
   logic [NUM_LANES-1:0][REM_W-1:0]     s5_rem_ff;
   logic [NUM_LANES-1:0][QUOT_W-1:0]    s5_quot_ff;
   logic [NUM_LANES-1:0]                s5_neg_ff, s5_ovf_ff;
   side_type                            s5_side_ff;

   always_comb begin
      s5_jq_ext = EXT_W'(s4_jq_ff);
      if (s4_cneg_ff) begin
         s5_jac_in = (s5_jq_ext > J_HALF) ? JAC_W'(J_HALF) : JAC_W'(-s5_jq_ext);
      end else begin
         s5_jac_in = (s5_jq_ext > J_MAX) ? JAC_W'(J_MAX) : JAC_W'(s5_jq_ext);
      end

      // rounding is done on floor(2n/d): the numerator is doubled up front
      for (int k = 0; k < NUM_LANES; k++) begin
         s5_twice[k]   = {s4_num_ff[k], 1'b0};
         s5_top[k]     = s5_twice[k][NUM_W:QUOT_W];
         s5_ovf_in[k]  = CMP_W'(s5_top[k]) >= CMP_W'(s4_div_ff);
         s5_rem_in[k]  = REM_W'(s5_top[k]);
         s5_quot_in[k] = s5_twice[k][QUOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_div_ff             <= s4_div_ff;
         s5_rem_ff             <= s5_rem_in;
         s5_quot_ff            <= s5_quot_in;
         s5_neg_ff             <= s4_neg_ff;
         s5_ovf_ff             <= s5_ovf_in;
         s5_side_ff.jacobian   <= s5_jac_in;
         s5_side_ff.status     <= s4_status_ff;
         s5_side_ff.final_flag <= s4_final_ff;
      end
   end

   assign out_valid   = s5_valid_ff;
   assign out_divisor = s5_div_ff;
   assign out_rem     = s5_rem_ff;
   assign out_quot    = s5_quot_ff;
   assign out_neg     = s5_neg_ff;
   assign out_ovf     = s5_ovf_ff;
   assign out_side    = s5_side_ff;

endmodule

// File: rtl/core/tgf_div_stage.sv
module tgf_div_stage
   import tgf_pkg::*;
#(
   parameter int REM_W = 2 * (COORD_WIDTH_DEFAULT + 1) + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [REM_W-1:0]                  in_divisor,
   input  logic [NUM_LANES-1:0][REM_W-1:0]   in_rem,
   input  logic [NUM_LANES-1:0][QUOT_W-1:0]  in_quot,
   input  logic [NUM_LANES-1:0]              in_neg,
   input  logic [NUM_LANES-1:0]              in_ovf,
   input  side_type                          in_side,
   output logic                              out_valid,
   output logic [REM_W-1:0]                  out_divisor,
   output logic [NUM_LANES-1:0][REM_W-1:0]   out_rem,
   output logic [NUM_LANES-1:0][QUOT_W-1:0]  out_quot,
   output logic [NUM_LANES-1:0]              out_neg,
   output logic [NUM_LANES-1:0]              out_ovf,
   output side_type                          out_side
);

   logic [NUM_LANES-1:0][REM_W:0]     trial;
   logic [NUM_LANES-1:0]              fits;
   logic [NUM_LANES-1:0][REM_W-1:0]   rem_in;
   logic [NUM_LANES-1:0][QUOT_W-1:0]  quot_in;
   logic                              valid_ff;
   logic [REM_W-1:0]                  divisor_ff;
   logic [NUM_LANES-1:0][REM_W-1:0]   rem_ff;
   logic [NUM_LANES-1:0][QUOT_W-1:0]  quot_ff;
   logic [NUM_LANES-1:0]              neg_ff, ovf_ff;
   side_type                          side_ff;

   // one restoring step: next dividend bit shifts out of the quotient word,
   // the new quotient bit shifts in at the bottom
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         trial[k]   = {in_rem[k], in_quot[k][QUOT_W-1]};
         fits[k]    = trial[k] >= {1'b0, in_divisor};
         rem_in[k]  = fits[k] ? REM_W'(trial[k] - {1'b0, in_divisor}) : REM_W'(trial[k]);
         quot_in[k] = {in_quot[k][QUOT_W-2:0], fits[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         divisor_ff <= in_divisor;
         rem_ff     <= rem_in;
         quot_ff    <= quot_in;
         neg_ff     <= in_neg;
         ovf_ff     <= in_ovf;
         side_ff    <= in_side;
      end
   end

   assign out_valid   = valid_ff;
   assign out_divisor = divisor_ff;
   assign out_rem     = rem_ff;
   assign out_quot    = quot_ff;
   assign out_neg     = neg_ff;
   assign out_ovf     = ovf_ff;
   assign out_side    = side_ff;

endmodule

// File: rtl/core/tgf_back.sv
module tgf_back
   import tgf_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [NUM_LANES-1:0][QUOT_W-1:0]  in_quot,
   input  logic [NUM_LANES-1:0]              in_neg,
   input  logic [NUM_LANES-1:0]              in_ovf,
   input  side_type                          in_side,
   output logic                              advance,
   output logic                              out_valid,
   input  logic                              out_ready,
   output rsp_type                           out_data
);

   localparam logic [QUOT_W-1:0] MAG_NEG = QUOT_W'(1) << (FACTOR_W - 1);
   localparam logic [QUOT_W-1:0] MAG_POS = MAG_NEG - QUOT_W'(1);

   logic [NUM_LANES-1:0][QUOT_W:0]    bumped;
   logic [NUM_LANES-1:0][QUOT_W-1:0]  rounded;
   rsp_type                           result_in;
   logic                              take;
   logic                              out_valid_ff, skid_valid_ff;
   rsp_type                           out_data_ff, skid_data_ff;

   // round half away from zero on the magnitude, then saturate
   always_comb begin
      result_in.jacobian   = in_side.jacobian;
      result_in.status     = in_side.status;
      result_in.final_flag = in_side.final_flag;
      for (int k = 0; k < NUM_LANES; k++) begin
         bumped[k]  = {1'b0, in_quot[k]} + (QUOT_W + 1)'(1);
         rounded[k] = bumped[k][QUOT_W:1];
         if (in_side.status != STATUS_OK) begin
            result_in.factor[k] = '0;
         end else if (in_neg[k]) begin
            result_in.factor[k] = (in_ovf[k] || rounded[k] > MAG_NEG) ?
                                  FACTOR_W'(MAG_NEG) : FACTOR_W'(-rounded[k]);
         end else begin
            result_in.factor[k] = (in_ovf[k] || rounded[k] > MAG_POS) ?
                                  FACTOR_W'(MAG_POS) : FACTOR_W'(rounded[k]);
         end
      end
   end

   assign advance = ~skid_valid_ff;
   assign take    = in_valid & advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= take;
         end
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result_in;
      end else if (take) begin
         skid_data_ff <= result_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
